FILE: hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int ID_W    = 8;
   localparam int PRI_W   = 8;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 32;

   localparam logic KIND_ARRIVE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_TICK,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic arrive;
      logic tick;
   } ctrl_cmd_type;

   typedef struct packed {
      logic kind;
   } ctrl_status_type;

endpackage

FILE: hdl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a bounded, priority-ordered ready queue.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. The
//   req_kind port selects a job arrival (req_job_id, req_job_priority,
//   req_burst_length) or one time tick. Every item gives exactly one result,
//   shown on the rsp_ ports for a single cycle while rsp_valid is high.
//   The receiver cannot stall, so the result must be captured in that cycle.
// Sequence:
//   After the accepting edge an arrival passes through ARRIVE and REPLY,
//   a tick through ARRIVE, TICK and REPLY; busy stays high until the result
//   has been shown, so a new item is not taken before the last one is done.
//   The queue slots compare and shift in parallel, so the sequence does not
//   depend on QUEUE_DEPTH; the controller states set it.
// Reset:
//   A synchronous active-high reset empties the queue, clears the time
//   counter and returns the controller to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic [ID_W-1:0]     req_job_id,
   input  logic [PRI_W-1:0]    req_job_priority,
   input  logic [BURST_W-1:0]  req_burst_length,
   output logic                rsp_valid,
   output logic                rsp_ran_valid,
   output logic [ID_W-1:0]     rsp_ran_id,
   output logic                rsp_finished,
   output logic                rsp_segment_valid,
   output logic [ID_W-1:0]     rsp_segment_id,
   output logic [TIME_W-1:0]   rsp_segment_start,
   output logic [TIME_W-1:0]   rsp_segment_end,
   output logic                rsp_rejected
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pps_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_job_id        (req_job_id),
      .req_job_priority  (req_job_priority),
      .req_burst_length  (req_burst_length),
      .rsp_ran_valid     (rsp_ran_valid),
      .rsp_ran_id        (rsp_ran_id),
      .rsp_finished      (rsp_finished),
      .rsp_segment_valid (rsp_segment_valid),
      .rsp_segment_id    (rsp_segment_id),
      .rsp_segment_start (rsp_segment_start),
      .rsp_segment_end   (rsp_segment_end),
      .rsp_rejected      (rsp_rejected)
   );

endmodule

FILE: hdl/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Controller state machine: takes an item, runs one datapath operation and
// strobes the result for one cycle.
// ----------------------------------------------------------------------------
module pps_ctrl
   import pps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            if (status.kind == KIND_TICK) begin
               state_in = ST_TICK;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_TICK: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_ARRIVE: begin
            cmd.arrive = (status.kind == KIND_ARRIVE);
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
         end
         ST_REPLY: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: hdl/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath
// Ready queue as a row of slots kept in descending priority order, the time
// counter and the result registers.
// ----------------------------------------------------------------------------
module pps_datapath
   import pps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_status_type     status,
   input  logic                req_kind,
   input  logic [ID_W-1:0]     req_job_id,
   input  logic [PRI_W-1:0]    req_job_priority,
   input  logic [BURST_W-1:0]  req_burst_length,
   output logic                rsp_ran_valid,
   output logic [ID_W-1:0]     rsp_ran_id,
   output logic                rsp_finished,
   output logic                rsp_segment_valid,
   output logic [ID_W-1:0]     rsp_segment_id,
   output logic [TIME_W-1:0]   rsp_segment_start,
   output logic [TIME_W-1:0]   rsp_segment_end,
   output logic                rsp_rejected
);

   logic                kind_ff;
   logic [ID_W-1:0]     new_id_ff;
   logic [PRI_W-1:0]    new_pri_ff;
   logic [BURST_W-1:0]  new_burst_ff;

   logic                valid_ff   [QUEUE_DEPTH];
   logic                valid_in   [QUEUE_DEPTH];
   logic                started_ff [QUEUE_DEPTH];
   logic                started_in [QUEUE_DEPTH];
   logic [ID_W-1:0]     id_ff      [QUEUE_DEPTH];
   logic [ID_W-1:0]     id_in      [QUEUE_DEPTH];
   logic [PRI_W-1:0]    pri_ff     [QUEUE_DEPTH];
   logic [PRI_W-1:0]    pri_in     [QUEUE_DEPTH];
   logic [BURST_W-1:0]  rem_ff     [QUEUE_DEPTH];
   logic [BURST_W-1:0]  rem_in     [QUEUE_DEPTH];
   logic [TIME_W-1:0]   stime_ff   [QUEUE_DEPTH];
   logic [TIME_W-1:0]   stime_in   [QUEUE_DEPTH];
   logic [TIME_W-1:0]   time_ff;
   logic [TIME_W-1:0]   time_in;

   logic                ran_valid_ff, ran_valid_in;
   logic [ID_W-1:0]     ran_id_ff, ran_id_in;
   logic                finished_ff, finished_in;
   logic                seg_valid_ff, seg_valid_in;
   logic [ID_W-1:0]     seg_id_ff, seg_id_in;
   logic [TIME_W-1:0]   seg_start_ff, seg_start_in;
   logic [TIME_W-1:0]   seg_end_ff, seg_end_in;
   logic                rejected_ff, rejected_in;

   logic [QUEUE_DEPTH-1:0] ge;
   logic [BURST_W-1:0]     new_rem;
   logic [TIME_W-1:0]      head_start;
   logic [TIME_W-1:0]      time_inc;

   assign status.kind = kind_ff;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ge[i] = valid_ff[i] && (pri_ff[i] >= new_pri_ff);
      end
   end

   assign new_rem    = (new_burst_ff == '0) ? BURST_W'(1) : new_burst_ff;
   assign head_start = started_ff[0] ? stime_ff[0] : time_ff;
   assign time_inc   = time_ff + TIME_W'(1);

   always_comb begin
      valid_in     = valid_ff;
      started_in   = started_ff;
      id_in        = id_ff;
      pri_in       = pri_ff;
      rem_in       = rem_ff;
      stime_in     = stime_ff;
      time_in      = time_ff;
      ran_valid_in = ran_valid_ff;
      ran_id_in    = ran_id_ff;
      finished_in  = finished_ff;
      seg_valid_in = seg_valid_ff;
      seg_id_in    = seg_id_ff;
      seg_start_in = seg_start_ff;
      seg_end_in   = seg_end_ff;
      rejected_in  = rejected_ff;

      if (cmd.arrive || cmd.tick) begin
         ran_valid_in = 1'b0;
         ran_id_in    = '0;
         finished_in  = 1'b0;
         seg_valid_in = 1'b0;
         seg_id_in    = '0;
         seg_start_in = '0;
         seg_end_in   = '0;
         rejected_in  = 1'b0;
      end

      if (cmd.arrive) begin
         if (valid_ff[QUEUE_DEPTH-1]) begin
            rejected_in = 1'b1;
         end else begin
            // A new head closes the running segment of a head that has started.
            if (!ge[0] && valid_ff[0] && started_ff[0]) begin
               seg_valid_in = 1'b1;
               seg_id_in    = id_ff[0];
               seg_start_in = stime_ff[0];
               seg_end_in   = time_ff;
            end
            if (!ge[0]) begin
               valid_in[0]   = 1'b1;
               started_in[0] = 1'b0;
               id_in[0]      = new_id_ff;
               pri_in[0]     = new_pri_ff;
               rem_in[0]     = new_rem;
               stime_in[0]   = '0;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (!ge[i]) begin
                  if (ge[i-1]) begin
                     valid_in[i]   = 1'b1;
                     started_in[i] = 1'b0;
                     id_in[i]      = new_id_ff;
                     pri_in[i]     = new_pri_ff;
                     rem_in[i]     = new_rem;
                     stime_in[i]   = '0;
                  end else begin
                     valid_in[i]   = valid_ff[i-1];
                     started_in[i] = (i == 1) ? 1'b0 : started_ff[i-1];
                     id_in[i]      = id_ff[i-1];
                     pri_in[i]     = pri_ff[i-1];
                     rem_in[i]     = rem_ff[i-1];
                     stime_in[i]   = stime_ff[i-1];
                  end
               end
            end
         end
      end

      if (cmd.tick) begin
         time_in = time_inc;
         if (valid_ff[0]) begin
            ran_valid_in = 1'b1;
            ran_id_in    = id_ff[0];
            if (rem_ff[0] <= BURST_W'(1)) begin
               finished_in  = 1'b1;
               seg_valid_in = 1'b1;
               seg_id_in    = id_ff[0];
               seg_start_in = head_start;
               seg_end_in   = time_inc;
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  valid_in[i]   = valid_ff[i+1];
                  started_in[i] = started_ff[i+1];
                  id_in[i]      = id_ff[i+1];
                  pri_in[i]     = pri_ff[i+1];
                  rem_in[i]     = rem_ff[i+1];
                  stime_in[i]   = stime_ff[i+1];
               end
               valid_in[QUEUE_DEPTH-1]   = 1'b0;
               started_in[QUEUE_DEPTH-1] = 1'b0;
            end else begin
               rem_in[0]     = rem_ff[0] - BURST_W'(1);
               started_in[0] = 1'b1;
               stime_in[0]   = head_start;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '{default: 1'b0};
         started_ff <= '{default: 1'b0};
         time_ff    <= '0;
      end else begin
         valid_ff   <= valid_in;
         started_ff <= started_in;
         time_ff    <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      pri_ff       <= pri_in;
      rem_ff       <= rem_in;
      stime_ff     <= stime_in;
      ran_valid_ff <= ran_valid_in;
      ran_id_ff    <= ran_id_in;
      finished_ff  <= finished_in;
      seg_valid_ff <= seg_valid_in;
      seg_id_ff    <= seg_id_in;
      seg_start_ff <= seg_start_in;
      seg_end_ff   <= seg_end_in;
      rejected_ff  <= rejected_in;
      if (cmd.load) begin
         kind_ff      <= req_kind;
         new_id_ff    <= req_job_id;
         new_pri_ff   <= req_job_priority;
         new_burst_ff <= req_burst_length;
      end
   end

   assign rsp_ran_valid     = ran_valid_ff;
   assign rsp_ran_id        = ran_id_ff;
   assign rsp_finished      = finished_ff;
   assign rsp_segment_valid = seg_valid_ff;
   assign rsp_segment_id    = seg_id_ff;
   assign rsp_segment_start = seg_start_ff;
   assign rsp_segment_end   = seg_end_ff;
   assign rsp_rejected      = rejected_ff;

endmodule

FILE: hdl/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_ran_valid,
   input logic rsp_finished,
   input logic rsp_segment_valid,
   input logic rsp_rejected
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an item was taken");

   a_reply_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block stayed busy after its result");

   a_finish_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_ran_valid && rsp_segment_valid))
      else $error("finished job without run or closed segment");

   a_reject_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (!rsp_ran_valid && !rsp_segment_valid))
      else $error("rejected arrival reported other activity");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

FILE: dv/preemptive_priority_scheduler_test.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_test
// Self-checking testbench for the preemptive priority scheduler. A short
// directed table covers idle ticks, extreme fields, zero bursts, preemption
// of started and unstarted heads, ties and a full queue. Random arrivals
// and ticks follow, in phases that fill and drain the queue. Each result is
// checked against its table row or a cycle-free model of the ready queue.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_test
   import pps_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH  = 8;
   localparam int RANDOM_ITEMS = 700;

   typedef struct packed {
      logic               kind;
      logic [ID_W-1:0]    job_id;
      logic [PRI_W-1:0]   job_priority;
      logic [BURST_W-1:0] burst_length;
   } job_item_type;

   typedef struct packed {
      logic              ran_valid;
      logic [ID_W-1:0]   ran_id;
      logic              finished;
      logic              segment_valid;
      logic [ID_W-1:0]   segment_id;
      logic [TIME_W-1:0] segment_start;
      logic [TIME_W-1:0] segment_end;
      logic              rejected;
   } outcome_type;

   typedef struct {
      logic               valid;
      logic [ID_W-1:0]    id;
      logic [PRI_W-1:0]   prio;
      logic [BURST_W-1:0] remaining;
      logic               started;
      logic [TIME_W-1:0]  start_time;
   } ready_slot_type;

   typedef struct {
      job_item_type item;
      bit           typed;
      outcome_type  want;
   } directed_row_type;

   localparam outcome_type NO_OUTCOME = '0;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_kind;
   logic [ID_W-1:0]    req_job_id;
   logic [PRI_W-1:0]   req_job_priority;
   logic [BURST_W-1:0] req_burst_length;
   logic               rsp_valid;
   logic               rsp_ran_valid;
   logic [ID_W-1:0]    rsp_ran_id;
   logic               rsp_finished;
   logic               rsp_segment_valid;
   logic [ID_W-1:0]    rsp_segment_id;
   logic [TIME_W-1:0]  rsp_segment_start;
   logic [TIME_W-1:0]  rsp_segment_end;
   logic               rsp_rejected;

   ready_slot_type    ready_queue[QUEUE_DEPTH];
   logic [TIME_W-1:0] sched_time;
   outcome_type       pending_outcomes[$];
   directed_row_type  directed_rows[$];
   int                mismatch_count = 0;
   int                burst_left = 0;

   preemptive_priority_scheduler #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_job_id(req_job_id),
      .req_job_priority(req_job_priority),
      .req_burst_length(req_burst_length),
      .rsp_valid(rsp_valid),
      .rsp_ran_valid(rsp_ran_valid),
      .rsp_ran_id(rsp_ran_id),
      .rsp_finished(rsp_finished),
      .rsp_segment_valid(rsp_segment_valid),
      .rsp_segment_id(rsp_segment_id),
      .rsp_segment_start(rsp_segment_start),
      .rsp_segment_end(rsp_segment_end),
      .rsp_rejected(rsp_rejected)
   );

   always #5 clock = ~clock;

   function automatic outcome_type schedule_step(input job_item_type it);
      outcome_type r;
      int          n;
      int          pos;
      r = NO_OUTCOME;
      n = 0;
      while (n < QUEUE_DEPTH && ready_queue[n].valid) n++;
      if (it.kind == KIND_ARRIVE) begin
         if (n >= QUEUE_DEPTH) begin
            r.rejected = 1'b1;
            return r;
         end
         pos = 0;
         while (pos < n && it.job_priority <= ready_queue[pos].prio) pos++;
         if (pos == 0 && n > 0 && ready_queue[0].started) begin
            r.segment_valid = 1'b1;
            r.segment_id    = ready_queue[0].id;
            r.segment_start = ready_queue[0].start_time;
            r.segment_end   = sched_time;
            ready_queue[0].started = 1'b0;
         end
         for (int i = n; i > pos; i--) ready_queue[i] = ready_queue[i-1];
         ready_queue[pos].valid      = 1'b1;
         ready_queue[pos].id         = it.job_id;
         ready_queue[pos].prio       = it.job_priority;
         ready_queue[pos].remaining  = (it.burst_length == '0) ? BURST_W'(1)
                                                               : it.burst_length;
         ready_queue[pos].started    = 1'b0;
         ready_queue[pos].start_time = '0;
         return r;
      end
      if (n == 0) begin
         sched_time = sched_time + TIME_W'(1);
         return r;
      end
      if (!ready_queue[0].started) begin
         ready_queue[0].started    = 1'b1;
         ready_queue[0].start_time = sched_time;
      end
      r.ran_valid = 1'b1;
      r.ran_id    = ready_queue[0].id;
      if (ready_queue[0].remaining > '0)
         ready_queue[0].remaining = ready_queue[0].remaining - BURST_W'(1);
      sched_time = sched_time + TIME_W'(1);
      if (ready_queue[0].remaining == '0) begin
         r.finished      = 1'b1;
         r.segment_valid = 1'b1;
         r.segment_id    = ready_queue[0].id;
         r.segment_start = ready_queue[0].start_time;
         r.segment_end   = sched_time;
         for (int i = 0; i + 1 < n; i++) ready_queue[i] = ready_queue[i+1];
         ready_queue[n-1].valid   = 1'b0;
         ready_queue[n-1].started = 1'b0;
      end
      return r;
   endfunction

   task automatic add_row(input logic kind, input logic [ID_W-1:0] id,
                          input logic [PRI_W-1:0] prio, input logic [BURST_W-1:0] burst,
                          input bit typed, input outcome_type want);
      directed_row_type row;
      row.item  = '{kind, id, prio, burst};
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic issue(input job_item_type it, input bit typed, input outcome_type want);
      outcome_type predicted;
      req_kind         <= it.kind;
      req_job_id       <= it.job_id;
      req_job_priority <= it.job_priority;
      req_burst_length <= it.burst_length;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = schedule_step(it);
      pending_outcomes.push_back(typed ? want : predicted);
   endtask

   task automatic pace();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("result with no item outstanding");
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("ran_valid", TIME_W'(want.ran_valid), TIME_W'(rsp_ran_valid));
            check_field("ran_id", TIME_W'(want.ran_id), TIME_W'(rsp_ran_id));
            check_field("finished", TIME_W'(want.finished), TIME_W'(rsp_finished));
            check_field("segment_valid", TIME_W'(want.segment_valid),
                        TIME_W'(rsp_segment_valid));
            check_field("segment_id", TIME_W'(want.segment_id), TIME_W'(rsp_segment_id));
            check_field("segment_start", want.segment_start, rsp_segment_start);
            check_field("segment_end", want.segment_end, rsp_segment_end);
            check_field("rejected", TIME_W'(want.rejected), TIME_W'(rsp_rejected));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      job_item_type it;
      int           arrive_pct;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ready_queue[i].valid   = 1'b0;
         ready_queue[i].started = 1'b0;
      end
      sched_time = '0;

      add_row(KIND_TICK,   8'h00, 8'h00, 16'h0000, 1'b1, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'hFF, 8'h00, 16'hFFFF, 1'b1, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h00, 8'hFF, 16'h0000, 1'b1, NO_OUTCOME);
      add_row(KIND_TICK,   8'hFF, 8'hFF, 16'hFFFF, 1'b1,
              outcome_type'{1'b1, 8'h00, 1'b1, 1'b1, 8'h00, 32'd1, 32'd2, 1'b0});
      add_row(KIND_TICK,   8'h00, 8'h00, 16'h0000, 1'b1,
              outcome_type'{1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0, 1'b0});
      add_row(KIND_ARRIVE, 8'h10, 8'h01, 16'h0002, 1'b1,
              outcome_type'{1'b0, 8'h00, 1'b0, 1'b1, 8'hFF, 32'd2, 32'd3, 1'b0});
      add_row(KIND_ARRIVE, 8'h11, 8'h01, 16'h0001, 1'b0, NO_OUTCOME);
      add_row(KIND_TICK,   8'h00, 8'h00, 16'h0000, 1'b0, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h12, 8'h01, 16'h0003, 1'b0, NO_OUTCOME);
      add_row(KIND_TICK,   8'h00, 8'h00, 16'h0000, 1'b0, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h20, 8'h80, 16'h0005, 1'b0, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h21, 8'h7F, 16'h0005, 1'b0, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h22, 8'h01, 16'h0005, 1'b0, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h23, 8'h00, 16'h0005, 1'b0, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h24, 8'hAA, 16'h0005, 1'b0, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h55, 8'hFF, 16'hFFFF, 1'b1,
              outcome_type'{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0, 1'b1});
      add_row(KIND_TICK,   8'h00, 8'h00, 16'h0000, 1'b0, NO_OUTCOME);
      add_row(KIND_ARRIVE, 8'h56, 8'hAA, 16'h5555, 1'b0, NO_OUTCOME);
      add_row(KIND_TICK,   8'h00, 8'h00, 16'h0000, 1'b0, NO_OUTCOME);

      reset            <= 1'b1;
      start            <= 1'b0;
      req_kind         <= KIND_ARRIVE;
      req_job_id       <= '0;
      req_job_priority <= '0;
      req_burst_length <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         issue(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
         pace();
      end

      arrive_pct = 30;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: arrive_pct = 15;
               1: arrive_pct = 30;
               default: arrive_pct = 60;
            endcase
         end
         it.job_id       = ID_W'($urandom_range(0, 255));
         it.job_priority = $urandom_range(0, 1) ? PRI_W'($urandom_range(0, 255))
                                                : PRI_W'($urandom_range(0, 3) * 64);
         case ($urandom_range(0, 19))
            0: it.burst_length = '0;
            1: it.burst_length = BURST_W'($urandom_range(7, 40));
            default: it.burst_length = BURST_W'($urandom_range(1, 6));
         endcase
         it.kind = ($urandom_range(0, 99) < arrive_pct) ? KIND_ARRIVE : KIND_TICK;
         issue(it, 1'b0, NO_OUTCOME);
         pace();
      end
      start <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/pps_pkg.sv
hdl/pps_ctrl.sv
hdl/pps_datapath.sv
hdl/preemptive_priority_scheduler.sv
hdl/pps_checker.sv
dv/preemptive_priority_scheduler_test.sv
